// ===== rtl/cmsd_pkg.sv =====
// Shared constants and types for the cross mean star detector.
package cmsd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 16;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int SUM_BITS   = 19;
    localparam int WIN_BITS   = 10;
    localparam int THR_BITS   = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_COL = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_COL  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_ROW = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_ROW  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 3'd4;

    localparam logic [WIN_BITS-1:0] FIRST_COL_RST = 10'd1;
    localparam logic [WIN_BITS-1:0] LAST_COL_RST  = 10'd1022;
    localparam logic [WIN_BITS-1:0] FIRST_ROW_RST = 10'd1;
    localparam logic [WIN_BITS-1:0] LAST_ROW_RST  = 10'd1022;
    localparam logic [SUM_BITS-1:0] THR5_RST      = 19'd30;

    localparam logic [COL_BITS-1:0] COL_LAST = COL_BITS'(MAX_WIDTH - 1);
    localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(MAX_HEIGHT - 1);

    typedef struct packed {
        logic [ROW_BITS-1:0] centre_row;
        logic [COL_BITS-1:0] centre_col;
        logic [SUM_BITS-1:0] cross_sum;
        logic                is_star;
    } t_result;

endpackage

// ===== rtl/cross_mean_star_detector_unit.sv =====
// o_out_valid rises after the pixel below its centre is taken, via the stage 1 registers and the result buffer.
// Throughput: one pixel per cycle while o_in_ready is high; one line-memory read-modify-write per pixel,
// with forwarding between back-to-back pixels, and a two-entry result buffer on the output.
// Reset (synchronous, active low) clears the row and column counters, valid flags and
// configuration registers; the line memory is not cleared, so reset makes no clearing pass.
// Configuration writes take effect at the next clock edge.
module cross_mean_star_detector_unit
    import cmsd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [PIXEL_BITS-1:0]    i_pixel_value,
    input  logic                     i_row_end,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ROW_BITS-1:0]      o_centre_row,
    output logic [COL_BITS-1:0]      o_centre_col,
    output logic [SUM_BITS-1:0]      o_cross_sum,
    output logic                     o_is_star
);

    localparam int WORD_BITS = 2 * PIXEL_BITS;

    // Line memory: upper line in the high half, middle line in the low half.
    logic [WORD_BITS-1:0] r_line_mem [MAX_WIDTH];

    logic [WIN_BITS-1:0] r_first_col;
    logic [WIN_BITS-1:0] r_last_col;
    logic [WIN_BITS-1:0] r_first_row;
    logic [WIN_BITS-1:0] r_last_row;
    logic [SUM_BITS-1:0] r_thr5;

    logic [COL_BITS-1:0] r_col;
    logic [ROW_BITS-1:0] r_row;

    logic                  r_s1_valid;
    logic                  r_s1_emit;
    logic [COL_BITS-1:0]   r_s1_col;
    logic [ROW_BITS-1:0]   r_s1_row;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [WORD_BITS-1:0]  r_rd_a;
    logic [PIXEL_BITS-1:0] r_rd_b;
    logic                  r_fwd_a;
    logic                  r_fwd_b;
    logic [WORD_BITS-1:0]  r_fwd_word;
    logic [PIXEL_BITS-1:0] r_left;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    logic                  w_in_acc;
    logic                  w_pop;
    logic                  w_push;
    logic [1:0]            w_pending;
    logic [2:0]            w_room;
    logic [COL_BITS-1:0]   w_col_p1;
    logic [ROW_BITS-1:0]   w_centre_row;
    logic                  w_emit;
    logic [PIXEL_BITS-1:0] w_up;
    logic [PIXEL_BITS-1:0] w_mid;
    logic [PIXEL_BITS-1:0] w_right;
    logic [WORD_BITS-1:0]  w_wdata;
    logic [SUM_BITS-1:0]   w_sum;
    t_result               w_res;
    logic [COL_BITS-1:0]   n_col;
    logic [ROW_BITS-1:0]   n_row;

    // Handshake and buffer occupancy.
    assign w_pop     = r_out_valid & i_out_ready;
    assign w_push    = r_s1_valid & r_s1_emit;
    assign w_pending = {1'b0, r_out_valid} + {1'b0, r_skid_valid};
    assign w_room    = {1'b0, w_pending} + {2'b00, w_push};
    assign o_in_ready = (w_room <= (3'd1 + {2'b00, w_pop}));
    assign w_in_acc  = i_in_valid & o_in_ready;

    // Stage 0: position, window check, memory read.
    assign w_col_p1     = r_col + 1'b1;
    assign w_centre_row = r_row - 1'b1;
    assign w_emit = (r_row >= ROW_BITS'(2)) && (r_col != '0) && (r_col != COL_LAST)
                 && (w_centre_row >= r_first_row) && (w_centre_row <= r_last_row)
                 && (r_col >= r_first_col) && (r_col <= r_last_col);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_row_end) begin
            n_col = '0;
            if (r_row != ROW_LAST) begin
                n_row = r_row + 1'b1;
            end
        end else if (r_col != COL_LAST) begin
            n_col = r_col + 1'b1;
        end
    end

    // Stage 1: forward, sum, compare, write back.
    assign w_up    = r_fwd_a ? r_fwd_word[WORD_BITS-1:PIXEL_BITS] : r_rd_a[WORD_BITS-1:PIXEL_BITS];
    assign w_mid   = r_fwd_a ? r_fwd_word[PIXEL_BITS-1:0] : r_rd_a[PIXEL_BITS-1:0];
    assign w_right = r_fwd_b ? r_fwd_word[PIXEL_BITS-1:0] : r_rd_b;
    assign w_wdata = {w_mid, r_s1_pix};
    assign w_sum   = SUM_BITS'(w_up) + SUM_BITS'(w_mid) + SUM_BITS'(r_left)
                   + SUM_BITS'(w_right) + SUM_BITS'(r_s1_pix);

    assign w_res.centre_row = r_s1_row;
    assign w_res.centre_col = r_s1_col;
    assign w_res.cross_sum  = w_sum;
    assign w_res.is_star    = (w_sum > r_thr5);

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd_a <= r_line_mem[r_col];
            r_rd_b <= r_line_mem[w_col_p1][PIXEL_BITS-1:0];
        end
        if (r_s1_valid) begin
            r_line_mem[r_s1_col] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_col   <= r_col;
            r_s1_row   <= w_centre_row;
            r_s1_pix   <= i_pixel_value;
            r_s1_emit  <= w_emit;
            r_fwd_a    <= r_s1_valid && (r_s1_col == r_col);
            r_fwd_b    <= r_s1_valid && (r_s1_col == w_col_p1);
            r_fwd_word <= w_wdata;
        end
        if (r_s1_valid) begin
            r_left <= w_mid;
        end
    end

    // Control state: counters, configuration, valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_first_col <= FIRST_COL_RST;
            r_last_col  <= LAST_COL_RST;
            r_first_row <= FIRST_ROW_RST;
            r_last_row  <= LAST_ROW_RST;
            r_thr5      <= THR5_RST;
        end else begin
            r_s1_valid <= w_in_acc;
            if (w_in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIRST_COL: r_first_col <= i_cfg_data[WIN_BITS-1:0];
                    CFG_LAST_COL:  r_last_col  <= i_cfg_data[WIN_BITS-1:0];
                    CFG_FIRST_ROW: r_first_row <= i_cfg_data[WIN_BITS-1:0];
                    CFG_LAST_ROW:  r_last_row  <= i_cfg_data[WIN_BITS-1:0];
                    CFG_THRESHOLD: begin
                        r_thr5 <= {SUM_BITS'(i_cfg_data[THR_BITS-1:0]) << 2}
                                + SUM_BITS'(i_cfg_data[THR_BITS-1:0]);
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result buffer: output register plus skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (r_skid_valid) begin
                if (w_pop) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= w_push;
                end
            end else if (r_out_valid) begin
                if (w_pop) begin
                    r_out_valid <= w_push;
                end else begin
                    r_skid_valid <= w_push;
                end
            end else begin
                r_out_valid <= w_push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_skid_valid) begin
            if (w_pop) begin
                r_out  <= r_skid;
                r_skid <= w_res;
            end
        end else if (r_out_valid && !w_pop) begin
            r_skid <= w_res;
        end else begin
            r_out <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_centre_row = r_out.centre_row;
    assign o_centre_col = r_out.centre_col;
    assign o_cross_sum  = r_out.cross_sum;
    assign o_is_star    = r_out.is_star;

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_skid_valid) |-> w_pop)
        else $error("result pushed into a full buffer");

    a_stage1_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted request did not reach stage 1");

    a_row_end_clears_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_row_end) |=> (r_col == '0))
        else $error("column counter not cleared at row end");

    a_border_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_emit) |-> (r_s1_col != '0 && r_s1_col != COL_LAST))
        else $error("border centre marked for output");

endmodule

// ===== dv/cross_mean_star_detector_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the cross mean star detector: raster pixel requests in, centres out.
module cross_mean_star_detector_unit_tb;
    import cmsd_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_PIXELS  = 100;
    localparam int RANDOM_PHASES = 10;
    localparam int WIN_LOW       = 1;
    localparam int WIN_HIGH      = 1022;
    localparam int THR_HIGH      = 65535;

    typedef enum {FILL_DARK, FILL_BRIGHT, FILL_FAINT, FILL_NOISE} t_fill;
    typedef logic [SUM_BITS+1:0] t_wide;

    class t_centre_tracker;
        logic [PIXEL_BITS-1:0] upper_row [MAX_WIDTH];
        logic [PIXEL_BITS-1:0] middle_row [MAX_WIDTH];
        logic [ROW_BITS-1:0] row_pos;
        logic [COL_BITS-1:0] col_pos;
        logic [WIN_BITS-1:0] first_col, last_col, first_row, last_row;
        logic [THR_BITS-1:0] threshold;
        t_result due_centres [$];
        int errors;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            row_pos = '0;
            col_pos = '0;
            first_col = FIRST_COL_RST;
            last_col = LAST_COL_RST;
            first_row = FIRST_ROW_RST;
            last_row = LAST_ROW_RST;
            threshold = THR_BITS'(THR5_RST / 5);
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_FIRST_COL: first_col = data[WIN_BITS-1:0];
                CFG_LAST_COL:  last_col = data[WIN_BITS-1:0];
                CFG_FIRST_ROW: first_row = data[WIN_BITS-1:0];
                CFG_LAST_ROW:  last_row = data[WIN_BITS-1:0];
                CFG_THRESHOLD: threshold = data[THR_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [PIXEL_BITS-1:0] pix, logic last);
            logic [PIXEL_BITS-1:0] above, here;
            logic [COL_BITS-1:0] c;
            logic [ROW_BITS-1:0] centre_row;
            t_wide sum;
            t_result res;
            c = col_pos;
            above = upper_row[c];
            here = middle_row[c];
            upper_row[c] = here;
            middle_row[c] = pix;
            centre_row = row_pos - 1'b1;
            if (row_pos >= 2 && c >= 1 && c != COL_LAST &&
                centre_row >= first_row && centre_row <= last_row &&
                c >= first_col && c <= last_col) begin
                sum = t_wide'(above) + t_wide'(here) + t_wide'(upper_row[c - 1]) +
                      t_wide'(middle_row[c + 1]) + t_wide'(pix);
                res.centre_row = centre_row;
                res.centre_col = c;
                res.cross_sum = SUM_BITS'(sum);
                res.is_star = (sum > t_wide'(threshold) * t_wide'(5));
                due_centres.push_back(res);
            end
            if (last) begin
                col_pos = '0;
                if (row_pos != ROW_LAST) row_pos++;
            end else if (col_pos != COL_LAST) begin
                col_pos++;
            end
        endfunction

        function void match_centre(t_result got);
            t_result want;
            if (due_centres.size() == 0) begin
                $display("%0t: unexpected centre: expected none, got row %0d col %0d sum %0d star %0b",
                         $time, got.centre_row, got.centre_col, got.cross_sum, got.is_star);
                errors++;
                return;
            end
            want = due_centres.pop_front();
            if (got.centre_row != want.centre_row) begin
                $display("%0t: centre_row expected %0d got %0d",
                         $time, want.centre_row, got.centre_row);
                errors++;
            end
            if (got.centre_col != want.centre_col) begin
                $display("%0t: centre_col expected %0d got %0d",
                         $time, want.centre_col, got.centre_col);
                errors++;
            end
            if (got.cross_sum != want.cross_sum) begin
                $display("%0t: cross_sum expected %0d got %0d",
                         $time, want.cross_sum, got.cross_sum);
                errors++;
            end
            if (got.is_star != want.is_star) begin
                $display("%0t: is_star expected %0b got %0b", $time, want.is_star, got.is_star);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [PIXEL_BITS-1:0]    i_pixel_value;
    logic                     i_row_end;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [ROW_BITS-1:0]      o_centre_row;
    logic [COL_BITS-1:0]      o_centre_col;
    logic [SUM_BITS-1:0]      o_cross_sum;
    logic                     o_is_star;

    cross_mean_star_detector_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_value (i_pixel_value),
        .i_row_end     (i_row_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_centre_row  (o_centre_row),
        .o_centre_col  (o_centre_col),
        .o_cross_sum   (o_cross_sum),
        .o_is_star     (o_is_star)
    );

    t_centre_tracker tracker;
    int gen_row;
    int mid_len;
    int up_len;
    int pixels_sent;
    bit tx_idle;
    bit rx_idle;
    bit hold_pending;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Shorten a row so that no centre in the window reads a line-buffer entry never written.
    function automatic int fit_row(input int want);
        int len, centre, lo, hi;
        len = want;
        centre = gen_row - 1;
        if (gen_row < 2 || centre < tracker.first_row || centre > tracker.last_row) return len;
        lo = (tracker.first_col > WIN_LOW) ? tracker.first_col : WIN_LOW;
        while (len > 1) begin
            hi = len - 1;
            if (hi > MAX_WIDTH - 2) hi = MAX_WIDTH - 2;
            if (hi > tracker.last_col) hi = tracker.last_col;
            if (hi < lo || (hi <= mid_len - 2 && hi <= up_len - 1)) break;
            len--;
        end
        return len;
    endfunction

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] value, input logic last);
        int gap;
        bit taken;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_value <= value;
        i_row_end <= last;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        tracker.take_pixel(value, last);
        pixels_sent++;
    endtask

    task automatic send_row(input int want, input t_fill fill);
        int len;
        int shown;
        logic [PIXEL_BITS-1:0] value;
        len = fit_row(want);
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_DARK:   value = '0;
                FILL_BRIGHT: value = '1;
                FILL_FAINT:  value = PIXEL_BITS'($urandom_range(0, 15));
                default: begin
                    value = PIXEL_BITS'($urandom);
                    if ($urandom_range(0, 7) == 0) value = ($urandom_range(0, 1) != 0) ? '1 : '0;
                end
            endcase
            send_pixel(value, i == len - 1);
        end
        shown = (len > MAX_WIDTH) ? MAX_WIDTH : len;
        if (gen_row >= 1 && up_len < shown && up_len < mid_len)
            up_len = (shown < mid_len) ? shown : mid_len;
        if (mid_len < shown) mid_len = shown;
        if (gen_row < MAX_HEIGHT - 1) gen_row++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_BITS'(value);
        @(posedge i_clk);
        tracker.set_reg(idx, CFG_DATA_BITS'(value));
    endtask

    task automatic set_window(input int fc, input int lc, input int fr, input int lr,
                              input int thr);
        write_reg(CFG_FIRST_COL, fc);
        write_reg(CFG_LAST_COL, lc);
        write_reg(CFG_FIRST_ROW, fr);
        write_reg(CFG_LAST_ROW, lr);
        write_reg(CFG_THRESHOLD, thr);
        i_cfg_we <= 1'b0;
    endtask

    task automatic shuffle_window();
        int fc, lc, fr, lr, thr;
        fc = ($urandom_range(0, 3) == 0) ? WIN_LOW : $urandom_range(WIN_LOW, 8);
        case ($urandom_range(0, 3))
            0: lc = WIN_HIGH;
            1: lc = fc + $urandom_range(0, 20);
            2: lc = $urandom_range(WIN_LOW, fc);
            default: lc = $urandom_range(fc, WIN_HIGH);
        endcase
        fr = ($urandom_range(0, 3) == 0) ? WIN_LOW : gen_row + $urandom_range(0, 6);
        if (fr > WIN_HIGH) fr = WIN_HIGH;
        case ($urandom_range(0, 3))
            0: lr = WIN_HIGH;
            1: lr = $urandom_range(WIN_LOW, fr);
            default: lr = fr + $urandom_range(0, 12);
        endcase
        if (lr > WIN_HIGH) lr = WIN_HIGH;
        case ($urandom_range(0, 4))
            0: thr = 0;
            1: thr = THR_HIGH;
            2: thr = $urandom_range(0, 20);
            default: thr = $urandom_range(0, THR_HIGH);
        endcase
        set_window(fc, lc, fr, lr, thr);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.due_centres.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int gap;
        bit took;
        t_result got;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = rx_idle ? $urandom_range(0, 10) : 0;
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                took = o_out_valid;
                if (took) begin
                    got.centre_row = o_centre_row;
                    got.centre_col = o_centre_col;
                    got.cross_sum = o_cross_sum;
                    got.is_star = o_is_star;
                    tracker.match_centre(got);
                end
                @(posedge i_clk);
            end while (!took);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(negedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int want;
        int shade;
        tracker = new();
        gen_row = 0;
        mid_len = 0;
        up_len = 0;
        pixels_sent = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_pending = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_pixel_value <= '0;
        i_row_end <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-scale pixels, then the same sum sitting exactly on the threshold
        send_row(6, FILL_BRIGHT);
        send_row(6, FILL_BRIGHT);
        send_row(5, FILL_BRIGHT);
        drain();
        set_window(tracker.first_col, tracker.last_col, tracker.first_row, tracker.last_row,
                   THR_HIGH);
        send_row(5, FILL_BRIGHT);
        send_row(3, FILL_DARK);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            shuffle_window();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            hold_pending = (p == 3);
            pixels_sent = 0;
            while (pixels_sent < PHASE_PIXELS) begin
                case ($urandom_range(0, 9))
                    0, 1: want = $urandom_range(1, 3);
                    2: want = $urandom_range(25, 60);
                    default: want = $urandom_range(4, 24);
                endcase
                shade = $urandom_range(0, 5);
                send_row(want, (shade < 3) ? t_fill'(shade) : FILL_NOISE);
            end
            drain();
        end

        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
